// ===== design/wang_tile_index_map_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Wang tile index map generator: assertion macros
// Concurrent assertion shorthands, clocked on aclk, off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WANG_TILE_INDEX_MAP_GENERATOR_MACROS_SVH
`define WANG_TILE_INDEX_MAP_GENERATOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define WTIM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define WTIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/wtim_pkg.sv =====
// ----------------------------------------------------------------------------
// Wang tile index map generator: package
// Widths, register codes, reset values and the tile packing helpers.
// ----------------------------------------------------------------------------
package wtim_pkg;

    localparam int MAX_GRID      = 1024;
    localparam int CNT_W         = $clog2(MAX_GRID);
    localparam int GRID_SIZE_W   = 11;
    localparam int COLOR_COUNT_W = 3;
    localparam int N_W           = ($clog2(MAX_GRID + 1) > GRID_SIZE_W) ?
                                   $clog2(MAX_GRID + 1) : GRID_SIZE_W;
    localparam int COLOR_W       = 2;
    localparam int COORD_W       = 10;
    localparam int TILE_W        = 8;
    localparam int PACK_W        = 4;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_SIZE   = 2'd0,
        CFG_COLOR_COUNT = 2'd1,
        CFG_CORNER_MODE = 2'd2
    } cfg_reg_t;

    localparam logic [GRID_SIZE_W-1:0]   GRID_SIZE_RST   = 11'd16;
    localparam logic [COLOR_COUNT_W-1:0] COLOR_COUNT_RST = 3'd2;

    // Corner key {ne, se, sw, nw} for each corner tile number.
    localparam logic [7:0] CORNER_PACK [16] = '{
        8'd0,  8'd16, 8'd68, 8'd1,
        8'd64, 8'd65, 8'd81, 8'd5,
        8'd17, 8'd84, 8'd85, 8'd69,
        8'd4,  8'd80, 8'd21, 8'd20
    };

    // Clip a color to the top color.
    function automatic logic [COLOR_W-1:0] sat_color(input logic [COLOR_W-1:0] v,
                                                      input logic [COLOR_W-1:0] top);
        return (v > top) ? top : v;
    endfunction

    // Fold an ordered color pair into one index.
    function automatic logic [PACK_W-1:0] pack_pair(input logic [COLOR_W-1:0] a,
                                                     input logic [COLOR_W-1:0] b);
        logic [4:0] a5;
        logic [4:0] b5;
        logic [4:0] r;
        a5 = 5'(a);
        b5 = 5'(b);
        if (a == b) begin
            r = (b != '0) ? 5'((a5 + 5'd1) * (a5 + 5'd1) - 5'd2) : 5'd0;
        end else if (a > b) begin
            r = (b != '0) ? 5'(a5 * a5 + 5'd2 * b5 - 5'd1)
                          : 5'((a5 + 5'd1) * (a5 + 5'd1) - 5'd1);
        end else begin
            r = 5'(5'd2 * a5 + b5 * b5);
        end
        return r[PACK_W-1:0];
    endfunction

    // Look up the corner tile number for four corner colors.
    function automatic logic [PACK_W-1:0] corner_tile(input logic [COLOR_W-1:0] ne,
                                                       input logic [COLOR_W-1:0] se,
                                                       input logic [COLOR_W-1:0] sw,
                                                       input logic [COLOR_W-1:0] nw);
        logic [7:0]        key;
        logic [PACK_W-1:0] r;
        key = {ne, se, sw, nw};
        r   = '0;
        for (int i = 15; i >= 0; i--) begin
            if (CORNER_PACK[i] == key) begin
                r = PACK_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== design/wtim_ram.sv =====
// ----------------------------------------------------------------------------
// Wang tile index map generator: generic RAM
// One write port, two registered read ports; a read returns the old data.
// ----------------------------------------------------------------------------
module wtim_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

// ===== design/wang_tile_index_map_generator.sv =====
// ----------------------------------------------------------------------------
// Wang tile index map generator
// Emits one cell of a toroidal Wang tile map per input beat, in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per map cell, four random colors in s_tdata.
//   m_ channel: one beat per cell with tile index and coordinates; m_tlast
//     marks the last cell of the map, after which the next map starts.
//   cfg_ channel: register writes (grid size, color count, corner mode),
//     always ready; write only while no cell is in flight.
// Output: an accepted cell's result is loaded into the output register that drives m_.
// Throughput: one cell per cycle while m_ is not stalled. Each row store is read at
//   the current and the next column; the north store is written at one column per
//   cell, the first-row store only in row 0. The read for the next cell is issued in
//   the cycle its predecessor is accepted, and its write is forwarded around the memory.
// Reset: counters go to cell (0, 0), registers to their reset values; the
//   row stores are not cleared and need no clearing pass.
// Stall: while m_tready is low the result holds in the output register and
//   s_tready drops until the beat is taken.
// ----------------------------------------------------------------------------
`include "wang_tile_index_map_generator_macros.svh"

module wang_tile_index_map_generator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input cells
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wtim_pkg::S_TDATA_W-1:0]       s_tdata,   // rand_a, rand_b, rand_c, rand_d
    // results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wtim_pkg::M_TDATA_W-1:0]       m_tdata,   // tile_index, cell_x, cell_y, pad
    output logic                                 m_tlast,   // map_done
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wtim_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wtim_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = wtim_pkg::COLOR_W;
    localparam int XW = wtim_pkg::CNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wtim_pkg::GRID_SIZE_W-1:0]   grid_size_reg;
    logic [wtim_pkg::COLOR_COUNT_W-1:0] color_count_reg;
    logic                               corner_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg   <= wtim_pkg::GRID_SIZE_RST;
            color_count_reg <= wtim_pkg::COLOR_COUNT_RST;
            corner_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                wtim_pkg::CFG_GRID_SIZE: begin
                    grid_size_reg <= cfg_data[wtim_pkg::GRID_SIZE_W-1:0];
                end
                wtim_pkg::CFG_COLOR_COUNT: begin
                    color_count_reg <= cfg_data[wtim_pkg::COLOR_COUNT_W-1:0];
                end
                wtim_pkg::CFG_CORNER_MODE: begin
                    corner_mode_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and cell counters
    // ------------------------------------------------------------------
    logic m_tvalid_reg;
    logic in_acc;

    // Take a new cell whenever the output register is empty or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    logic [XW-1:0] col_reg, col_next;
    logic [XW-1:0] row_reg, row_next;
    logic [XW-1:0] col_p1;
    logic [XW-1:0] rd_col;

    logic [wtim_pkg::N_W-1:0] gs_ext, n_clamped;
    logic                     last_col, last_row, x0, y0;

    always_comb begin
        gs_ext = wtim_pkg::N_W'(grid_size_reg);
        if (gs_ext == '0) begin
            n_clamped = wtim_pkg::N_W'(1);
        end else if (gs_ext > wtim_pkg::N_W'(wtim_pkg::MAX_GRID)) begin
            n_clamped = wtim_pkg::N_W'(wtim_pkg::MAX_GRID);
        end else begin
            n_clamped = gs_ext;
        end
    end

    assign last_col = (wtim_pkg::N_W'(col_reg) + wtim_pkg::N_W'(1)) >= n_clamped;
    assign last_row = (wtim_pkg::N_W'(row_reg) + wtim_pkg::N_W'(1)) >= n_clamped;
    assign x0       = (col_reg == '0);
    assign y0       = (row_reg == '0);
    assign col_p1   = col_reg + XW'(1);

    // Advance in raster order; wrap both counters at the map edge.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + XW'(1);
            end else begin
                col_next = col_p1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read the stores at the column the next cell will see.
    assign rd_col = col_next;

    // ------------------------------------------------------------------
    // Row stores with last-write forwarding
    // ------------------------------------------------------------------
    logic          nr_we, fr_we;
    logic [XW-1:0] nr_waddr, fr_waddr;
    logic [CW-1:0] nr_wdata, fr_wdata;
    logic [CW-1:0] nr_ra, nr_rb, fr_ra, fr_rb;

    wtim_ram #(.WIDTH(CW), .DEPTH(wtim_pkg::MAX_GRID)) u_north_ram (
        .aclk    (aclk),
        .we      (nr_we),
        .waddr   (nr_waddr),
        .wdata   (nr_wdata),
        .ra_addr (rd_col),
        .ra_data (nr_ra),
        .rb_addr (rd_col + XW'(1)),
        .rb_data (nr_rb)
    );

    wtim_ram #(.WIDTH(CW), .DEPTH(wtim_pkg::MAX_GRID)) u_first_ram (
        .aclk    (aclk),
        .we      (fr_we),
        .waddr   (fr_waddr),
        .wdata   (fr_wdata),
        .ra_addr (rd_col),
        .ra_data (fr_ra),
        .rb_addr (rd_col + XW'(1)),
        .rb_data (fr_rb)
    );

    // The write issued at the edge that sampled the read data is not in it yet.
    logic          nr_lw_valid_reg, fr_lw_valid_reg;
    logic [XW-1:0] nr_lw_addr_reg, fr_lw_addr_reg;
    logic [CW-1:0] nr_lw_data_reg, fr_lw_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nr_lw_valid_reg <= 1'b0;
            fr_lw_valid_reg <= 1'b0;
        end else begin
            nr_lw_valid_reg <= nr_we;
            fr_lw_valid_reg <= fr_we;
        end
        nr_lw_addr_reg <= nr_waddr;
        nr_lw_data_reg <= nr_wdata;
        fr_lw_addr_reg <= fr_waddr;
        fr_lw_data_reg <= fr_wdata;
    end

    // Entry zero of each store lives in a register as well: it is read at
    // the wrap column while another column is read and written.
    logic [CW-1:0] nr0_reg, fr0_reg;

    logic [CW-1:0] north_x, north_x1, first_x, first_x1;

    always_comb begin
        north_x  = (nr_lw_valid_reg && nr_lw_addr_reg == col_reg) ? nr_lw_data_reg : nr_ra;
        north_x1 = (nr_lw_valid_reg && nr_lw_addr_reg == col_p1)  ? nr_lw_data_reg : nr_rb;
        first_x  = (fr_lw_valid_reg && fr_lw_addr_reg == col_reg) ? fr_lw_data_reg : fr_ra;
        first_x1 = (fr_lw_valid_reg && fr_lw_addr_reg == col_p1)  ? fr_lw_data_reg : fr_rb;
        if (x0) begin
            north_x = nr0_reg;
            first_x = fr0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Cell logic
    // ------------------------------------------------------------------
    logic [CW-1:0] prev_east_reg, row_first_west_reg;

    logic [wtim_pkg::COLOR_COUNT_W-1:0] c_clamped;
    logic [CW-1:0]  top;
    logic [4:0]     cc;
    logic [CW-1:0]  fa, fb, fc, fd;
    logic [CW-1:0]  e_s, e_w, e_n, e_e;
    logic [CW-1:0]  k_sw, k_se, k_nw, k_ne, k_rfw, k_fr0;
    logic [8:0]     edge_tile;
    logic [wtim_pkg::TILE_W-1:0] tile;
    logic [CW-1:0]  east_out, west_first;

    always_comb begin
        if (color_count_reg < wtim_pkg::COLOR_COUNT_W'(2)) begin
            c_clamped = wtim_pkg::COLOR_COUNT_W'(2);
        end else if (color_count_reg > wtim_pkg::COLOR_COUNT_W'(4)) begin
            c_clamped = wtim_pkg::COLOR_COUNT_W'(4);
        end else begin
            c_clamped = color_count_reg;
        end
        top = corner_mode_reg ? CW'(1) : CW'(c_clamped - wtim_pkg::COLOR_COUNT_W'(1));
        cc  = 5'(c_clamped) * 5'(c_clamped);

        fa = wtim_pkg::sat_color(s_tdata[1:0], top);
        fb = wtim_pkg::sat_color(s_tdata[3:2], top);
        fc = wtim_pkg::sat_color(s_tdata[5:4], top);
        fd = wtim_pkg::sat_color(s_tdata[7:6], top);

        // Edge tiles: the south edge written this cell is the north source
        // only on a one-row map.
        e_s = y0 ? fa : north_x;
        e_w = x0 ? fb : prev_east_reg;
        e_n = !last_row ? fc : (y0 ? e_s : first_x);
        e_e = !last_col ? fd : (x0 ? e_w : row_first_west_reg);
        edge_tile = 9'(wtim_pkg::pack_pair(e_s, e_n)) * 9'(cc)
                  + 9'(wtim_pkg::pack_pair(e_w, e_e));

        // Corner tiles.
        k_fr0 = (y0 && x0) ? fa : fr0_reg;
        k_sw  = y0 ? (x0 ? fa : first_x) : north_x;
        k_rfw = x0 ? k_sw : row_first_west_reg;
        k_se  = !last_col ? (y0 ? fb : north_x1) : k_rfw;
        k_nw  = x0 ? (!last_row ? fc : k_fr0) : prev_east_reg;
        k_ne  = !last_col ? (!last_row ? fd : first_x1) : (x0 ? k_nw : nr0_reg);

        if (corner_mode_reg) begin
            tile       = wtim_pkg::TILE_W'(wtim_pkg::corner_tile(k_ne, k_se, k_sw, k_nw));
            east_out   = k_ne;
            west_first = k_sw;
            nr_wdata   = k_nw;
            fr_we      = in_acc && y0 && !last_col;
            fr_waddr   = col_p1;
            fr_wdata   = k_se;
        end else begin
            tile       = edge_tile[wtim_pkg::TILE_W-1:0];
            east_out   = e_e;
            west_first = e_w;
            nr_wdata   = e_n;
            fr_we      = in_acc && y0;
            fr_waddr   = col_reg;
            fr_wdata   = e_s;
        end
        nr_we    = in_acc;
        nr_waddr = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_east_reg      <= '0;
            row_first_west_reg <= '0;
        end else if (in_acc) begin
            prev_east_reg <= east_out;
            if (x0) begin
                row_first_west_reg <= west_first;
            end
        end
    end

    // Mirror entry zero; fresh lower-west color in both modes.
    always_ff @(posedge aclk) begin
        if (in_acc && x0) begin
            nr0_reg <= nr_wdata;
            if (y0) begin
                fr0_reg <= fa;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [wtim_pkg::TILE_W-1:0]  tile_reg;
    logic [wtim_pkg::COORD_W-1:0] cell_x_reg, cell_y_reg;
    logic                         map_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_acc) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (in_acc) begin
            tile_reg     <= tile;
            cell_x_reg   <= wtim_pkg::COORD_W'(col_reg);
            cell_y_reg   <= wtim_pkg::COORD_W'(row_reg);
            map_done_reg <= last_col && last_row;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = map_done_reg;
    assign m_tdata  = {(wtim_pkg::M_TDATA_W - wtim_pkg::TILE_W - 2 * wtim_pkg::COORD_W)'(0),
                       cell_y_reg, cell_x_reg, tile_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WTIM_ASSERT_NEXT(a_col_wrap, in_acc && last_col, col_reg == '0,
                      "column did not wrap after the last column")
    `WTIM_ASSERT_NEXT(a_col_step, in_acc && !last_col, col_reg == $past(col_reg) + XW'(1),
                      "column did not advance by one")
    `WTIM_ASSERT_NOW(a_fr_corner_addr, corner_mode_reg && fr_we, fr_waddr != '0,
                     "corner first-row write hit entry zero")
    `WTIM_ASSERT_NEXT(a_out_loaded, in_acc, m_tvalid_reg,
                      "accepted cell left no result")

endmodule

// ===== sim/wang_tile_index_map_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wang tile index map generator testbench
// Streams map cells with random colors through the block and checks every
// result beat against a cycle-free predictor of the toroidal tile map. Covers
// edge and corner tiles, color saturation, register clamping, a grid shrink in
// the middle of a map, a grid written above the limit, and random maps under
// idling on both sides.
// ----------------------------------------------------------------------------
module wang_tile_index_map_generator_tb;

    localparam int TIMEOUT_CYCLES = 400000;

    // Corner key {ne, se, sw, nw} per corner tile number.
    localparam logic [7:0] CORNER_KEYS [16] = '{
        8'd0,  8'd16, 8'd68, 8'd1,
        8'd64, 8'd65, 8'd81, 8'd5,
        8'd17, 8'd84, 8'd85, 8'd69,
        8'd4,  8'd80, 8'd21, 8'd20
    };

    typedef struct packed {
        logic                         map_done;
        logic [wtim_pkg::COORD_W-1:0] y;
        logic [wtim_pkg::COORD_W-1:0] x;
        logic [wtim_pkg::TILE_W-1:0]  tile;
    } map_beat_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [wtim_pkg::S_TDATA_W-1:0]   s_tdata;   // rand_a, rand_b, rand_c, rand_d
    logic                             m_tvalid;
    logic                             m_tready;
    logic [wtim_pkg::M_TDATA_W-1:0]   m_tdata;   // tile_index, cell_x, cell_y, pad
    logic                             m_tlast;   // map_done
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [wtim_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [wtim_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Register shadows, as the block holds them.
    logic [wtim_pkg::GRID_SIZE_W-1:0]   grid_size_q;
    logic [wtim_pkg::COLOR_COUNT_W-1:0] color_count_q;
    logic                               corner_mode_q;

    // Map state of the predictor.
    int               col_cnt;
    int               row_cnt;
    logic [wtim_pkg::COLOR_W-1:0] north_colors [wtim_pkg::MAX_GRID];
    logic [wtim_pkg::COLOR_W-1:0] first_row_colors [wtim_pkg::MAX_GRID];
    logic [wtim_pkg::COLOR_W-1:0] last_east;
    logic [wtim_pkg::COLOR_W-1:0] row_west;

    map_beat_t expected_beats [$];
    int        mismatches;
    int        tx_idle_pct;
    int        rx_stall_pct;
    int        hold_pct;

    wang_tile_index_map_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Clip a random color to the top color of the palette.
    function automatic logic [wtim_pkg::COLOR_W-1:0] clip_color(
        input logic [wtim_pkg::COLOR_W-1:0] v,
        input int                           top);
        return (int'(v) > top) ? wtim_pkg::COLOR_W'(top) : v;
    endfunction

    // Fold an ordered color pair into one palette index.
    function automatic int fold_pair(input int a, input int b);
        if (a == b) begin
            return (b > 0) ? (a + 1) * (a + 1) - 2 : 0;
        end
        if (a > b) begin
            return (b > 0) ? a * a + 2 * b - 1 : (a + 1) * (a + 1) - 1;
        end
        return 2 * a + b * b;
    endfunction

    function automatic int corner_lookup(input logic [wtim_pkg::COLOR_W-1:0] ne,
                                         input logic [wtim_pkg::COLOR_W-1:0] se,
                                         input logic [wtim_pkg::COLOR_W-1:0] sw,
                                         input logic [wtim_pkg::COLOR_W-1:0] nw);
        logic [7:0] key;
        key = {ne, se, sw, nw};
        for (int i = 0; i < 16; i++) begin
            if (CORNER_KEYS[i] == key) begin
                return i;
            end
        end
        return 0;
    endfunction

    // Work out the result beat of one accepted cell and advance the map.
    task automatic predict_tile(input logic [wtim_pkg::S_TDATA_W-1:0] colors);
        int                           dim;
        int                           x;
        int                           y;
        int                           palette;
        int                           tile;
        bit                           last_col;
        bit                           last_row;
        logic [wtim_pkg::COLOR_W-1:0] ra;
        logic [wtim_pkg::COLOR_W-1:0] rb;
        logic [wtim_pkg::COLOR_W-1:0] rc;
        logic [wtim_pkg::COLOR_W-1:0] rd;
        logic [wtim_pkg::COLOR_W-1:0] south;
        logic [wtim_pkg::COLOR_W-1:0] west;
        logic [wtim_pkg::COLOR_W-1:0] north;
        logic [wtim_pkg::COLOR_W-1:0] east;
        logic [wtim_pkg::COLOR_W-1:0] sw;
        logic [wtim_pkg::COLOR_W-1:0] se;
        logic [wtim_pkg::COLOR_W-1:0] nw;
        logic [wtim_pkg::COLOR_W-1:0] ne;
        map_beat_t                    beat;

        ra = colors[1:0];
        rb = colors[3:2];
        rc = colors[5:4];
        rd = colors[7:6];
        dim = int'(grid_size_q);
        if (dim < 1) dim = 1;
        if (dim > wtim_pkg::MAX_GRID) dim = wtim_pkg::MAX_GRID;
        x = col_cnt;
        y = row_cnt;
        last_col = (x + 1 >= dim);
        last_row = (y + 1 >= dim);

        if (!corner_mode_q) begin
            palette = int'(color_count_q);
            if (palette < 2) palette = 2;
            if (palette > 4) palette = 4;
            if (y == 0) begin
                south = clip_color(ra, palette - 1);
                first_row_colors[x] = south;
            end else begin
                south = north_colors[x];
            end
            if (x == 0) begin
                west = clip_color(rb, palette - 1);
                row_west = west;
            end else begin
                west = last_east;
            end
            north = !last_row ? clip_color(rc, palette - 1) : first_row_colors[x];
            north_colors[x] = north;
            east = !last_col ? clip_color(rd, palette - 1) : row_west;
            last_east = east;
            tile = fold_pair(south, north) * palette * palette + fold_pair(west, east);
        end else begin
            // Corner tiles: two colors, lower corners shared with the row below.
            if (y == 0) begin
                if (x == 0) begin
                    sw = clip_color(ra, 1);
                    first_row_colors[0] = sw;
                    row_west = sw;
                end else begin
                    sw = first_row_colors[x];
                end
                if (!last_col) begin
                    se = clip_color(rb, 1);
                    first_row_colors[x + 1] = se;
                end else begin
                    se = row_west;
                end
            end else begin
                sw = north_colors[x];
                if (x == 0) row_west = sw;
                se = !last_col ? north_colors[x + 1] : row_west;
            end
            if (x == 0) begin
                nw = !last_row ? clip_color(rc, 1) : first_row_colors[0];
            end else begin
                nw = last_east;
            end
            north_colors[x] = nw;
            if (!last_col) begin
                ne = !last_row ? clip_color(rd, 1) : first_row_colors[x + 1];
            end else begin
                ne = north_colors[0];
            end
            last_east = ne;
            tile = corner_lookup(ne, se, sw, nw);
        end

        beat.tile     = wtim_pkg::TILE_W'(tile);
        beat.x        = wtim_pkg::COORD_W'(x);
        beat.y        = wtim_pkg::COORD_W'(y);
        beat.map_done = last_col && last_row;
        expected_beats = {expected_beats, beat};

        // Raster order with wraparound after the last cell.
        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end else begin
            col_cnt = x + 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
        mismatches++;
    endtask

    // Compare each accepted result beat with the oldest pending prediction.
    always @(posedge aclk) begin : check_results
        map_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected beat, tile_index",
                                int'(m_tdata[wtim_pkg::TILE_W-1:0]), -1);
            end else begin
                want = expected_beats.pop_front();
                if (m_tdata[wtim_pkg::TILE_W-1:0] !== want.tile)
                    report_mismatch("tile_index", int'(m_tdata[wtim_pkg::TILE_W-1:0]),
                                    int'(want.tile));
                if (m_tdata[wtim_pkg::TILE_W +: wtim_pkg::COORD_W] !== want.x)
                    report_mismatch("cell_x",
                                    int'(m_tdata[wtim_pkg::TILE_W +: wtim_pkg::COORD_W]),
                                    int'(want.x));
                if (m_tdata[wtim_pkg::TILE_W+wtim_pkg::COORD_W +: wtim_pkg::COORD_W]
                    !== want.y)
                    report_mismatch("cell_y",
                                    int'(m_tdata[wtim_pkg::TILE_W+wtim_pkg::COORD_W +:
                                                 wtim_pkg::COORD_W]),
                                    int'(want.y));
                if (m_tlast !== want.map_done)
                    report_mismatch("map_done", int'(m_tlast), int'(want.map_done));
            end
        end
    end

    // Receiver: stall at random, at the rate the current phase asks.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Watchdog: end the run if the stream hangs.
    initial begin : watchdog
        int cycles = 0;
        while (cycles < TIMEOUT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("** wang_tile_index_map_generator: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one map cell; predict its result once the beat is taken.
    task automatic send_cell(input logic [wtim_pkg::S_TDATA_W-1:0] colors);
        if ($urandom_range(0, 99) < hold_pct) begin
            // Hold off until the block has handed over every pending result.
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (expected_beats.size() != 0);
        end else if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= colors;
        do @(posedge aclk); while (!s_tready);
        predict_tile(colors);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_cell(8'($urandom()));
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write all three registers back to back; valid stays high between beats.
    task automatic write_config(input logic [wtim_pkg::CFG_DATA_W-1:0] grid,
                                input logic [wtim_pkg::CFG_DATA_W-1:0] colors,
                                input logic [wtim_pkg::CFG_DATA_W-1:0] mode);
        wtim_pkg::cfg_reg_t              idx [3];
        logic [wtim_pkg::CFG_DATA_W-1:0] val [3];
        idx = '{wtim_pkg::CFG_GRID_SIZE, wtim_pkg::CFG_COLOR_COUNT,
                wtim_pkg::CFG_CORNER_MODE};
        val = '{grid, colors, mode};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                wtim_pkg::CFG_GRID_SIZE:
                    grid_size_q   = val[i][wtim_pkg::GRID_SIZE_W-1:0];
                wtim_pkg::CFG_COLOR_COUNT:
                    color_count_q = val[i][wtim_pkg::COLOR_COUNT_W-1:0];
                wtim_pkg::CFG_CORNER_MODE:
                    corner_mode_q = val[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: edge map with grid size 16 and two colors; saturate the top colors.
    // Then drop to a grid of zero, which clamps to one, in the middle of row 0.
    task automatic test_reset_defaults();
        send_cell(8'h00);
        send_cell(8'hFF);
        send_cell(8'h9C);
        drain_results();
        write_config(11'd0, 11'd2, 11'd0);
        send_cell(8'h63);   // counter beyond the grid: last column and last row
        send_cell(8'hFF);
        send_cell(8'h00);
        drain_results();
    endtask

    // Edge tiles over the color count range, clamped values included.
    task automatic test_edge_colors();
        write_config(11'd2, 11'd4, 11'd0);
        send_cell(8'h00);
        send_cell(8'hFF);
        send_cell(8'h1B);
        send_cell(8'hE4);
        drain_results();
        write_config(11'd3, 11'd7, 11'd0);   // clamps to four colors
        send_random(9);
        drain_results();
        write_config(11'd2, 11'h7F9, 11'd0); // low bits one: clamps to two colors
        send_cell(8'hFF);
        send_cell(8'hAA);
        send_cell(8'h55);
        send_cell(8'h00);
        drain_results();
    endtask

    // Corner tiles: always two colors, whatever the color count says.
    task automatic test_corner_mode();
        write_config(11'd2, 11'd4, 11'd1);
        send_cell(8'h00);
        send_cell(8'hFF);
        send_cell(8'h55);
        send_cell(8'hAA);
        drain_results();
        write_config(11'd3, 11'd3, 11'h7FF);
        send_random(9);
        drain_results();
        write_config(11'd0, 11'd2, 11'd1);
        send_cell(8'hFF);
        send_cell(8'h00);
        drain_results();
    endtask

    // Shrink the grid in the middle of a map: the next cell sits past the new
    // last column and last row, closes the map and wraps to the origin.
    task automatic test_grid_shrink();
        write_config(11'd5, 11'd3, 11'd0);
        send_random(18);
        drain_results();
        write_config(11'd2, 11'd3, 11'd0);
        send_random(5);
        drain_results();
    endtask

    // Grid written above the limit: part of a long first row, then shrink to
    // two so the next cell closes row 0 and one more row ends the map.
    task automatic test_large_grid();
        write_config(11'd2047, 11'd4, 11'd0);
        send_random(40);
        drain_results();
        write_config(11'd2, 11'd4, 11'd0);
        send_random(3);
        drain_results();
    endtask

    // Whole maps of random size, colors and mode until the target is reached.
    task automatic test_random_maps(input int target, input int tx_pct, input int rx_pct);
        int                              sent;
        int                              pick;
        int                              dim;
        logic [wtim_pkg::CFG_DATA_W-1:0] grid;
        sent         = 0;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        hold_pct     = 2;
        while (sent < target) begin
            drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                grid = wtim_pkg::CFG_DATA_W'($urandom_range(9, 12));
            end else if (pick < 30) begin
                grid = wtim_pkg::CFG_DATA_W'($urandom_range(5, 8));
            end else begin
                grid = wtim_pkg::CFG_DATA_W'($urandom_range(0, 4));
            end
            write_config(grid, wtim_pkg::CFG_DATA_W'($urandom()),
                         wtim_pkg::CFG_DATA_W'($urandom()));
            dim = (grid == 0) ? 1 : int'(grid);
            send_random(dim * dim);
            sent += dim * dim;
        end
        hold_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        m_tready      <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= wtim_pkg::CFG_GRID_SIZE;
        cfg_data      <= '0;
        aresetn       <= 1'b0;
        grid_size_q   = wtim_pkg::GRID_SIZE_RST;
        color_count_q = wtim_pkg::COLOR_COUNT_RST;
        corner_mode_q = 1'b0;
        col_cnt       = 0;
        row_cnt       = 0;
        last_east     = '0;
        row_west      = '0;
        mismatches    = 0;
        tx_idle_pct   = 18;
        rx_stall_pct  = 49;
        hold_pct      = 0;
        for (int i = 0; i < wtim_pkg::MAX_GRID; i++) begin
            north_colors[i]     = '0;
            first_row_colors[i] = '0;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_edge_colors();
        test_corner_mode();
        test_grid_shrink();
        test_large_grid();
        test_random_maps(110, 18, 49);
        test_random_maps(110, 49, 18);
        test_random_maps(110, 0, 0);

        // Let the last beat settle before the verdict.
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** wang_tile_index_map_generator: PASSED **");
        end else begin
            $display("** wang_tile_index_map_generator: FAILED **");
        end
        $finish;
    end

endmodule
